// ===== design/cpem_pkg.sv =====
// Shared constants, types and saturating arithmetic for the channel power and energy meter.
package cpem_pkg;

  // Channel count and store addressing.
  localparam int CHANNELS = 8;
  localparam int ADDR_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // Field widths.
  localparam int CH_W   = 3;
  localparam int CUR_W  = 16;
  localparam int MV_W   = 16;
  localparam int ST_W   = 3;
  localparam int PWR_W  = 32;
  localparam int ENE_W  = 64;
  localparam int ONT_W  = 64;
  localparam int TP_W   = 35;
  localparam int TICK_W = 32;

  localparam logic [TICK_W-1:0] TICK_RESET = 32'd1000000;

  // Stream payload widths, padded to whole bytes.
  localparam int IN_FIELDS_W  = CUR_W + MV_W + ST_W;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = PWR_W + PWR_W + ENE_W + ONT_W + TP_W + ENE_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  // Channel state codes that count as conducting.
  localparam logic [ST_W-1:0] ST_ON    = 3'd1;
  localparam logic [ST_W-1:0] ST_OC_ON = 3'd2;
  localparam logic [ST_W-1:0] ST_OP_ON = 3'd3;

  // One store entry per channel.
  typedef struct packed {
    logic [ONT_W-1:0] on_time;
    logic [ENE_W-1:0] energy;
    logic [PWR_W-1:0] peak;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Signed 64-bit add, clamped to the signed limits.
  function automatic logic [ENE_W-1:0] sat_add_s64(logic [ENE_W-1:0] a, logic [ENE_W-1:0] b);
    logic [ENE_W-1:0] s;
    s = a + b;
    if ((a[ENE_W-1] == b[ENE_W-1]) && (s[ENE_W-1] != a[ENE_W-1])) begin
      s = a[ENE_W-1] ? {1'b1, {(ENE_W-1){1'b0}}} : {1'b0, {(ENE_W-1){1'b1}}};
    end
    return s;
  endfunction

  // Unsigned 64-bit add, clamped to all ones.
  function automatic logic [ONT_W-1:0] sat_add_u64(logic [ONT_W-1:0] a, logic [ONT_W-1:0] b);
    logic [ONT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[ONT_W] ? {ONT_W{1'b1}} : s[ONT_W-1:0];
  endfunction

  // 35-bit signed sweep sum plus a 32-bit signed power, clamped to 35 bits.
  function automatic logic [TP_W-1:0] sat_add_tp(logic [TP_W-1:0] a, logic [PWR_W-1:0] b);
    logic [TP_W:0] s;
    s = {a[TP_W-1], a} + {{(TP_W+1-PWR_W){b[PWR_W-1]}}, b};
    if (s[TP_W] != s[TP_W-1]) begin
      s[TP_W-1:0] = s[TP_W] ? {1'b1, {(TP_W-1){1'b0}}} : {1'b0, {(TP_W-1){1'b1}}};
    end
    return s[TP_W-1:0];
  endfunction

endpackage

// ===== design/cpem_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
module cpem_ram #(
  parameter int Width = 8,
  parameter int Depth = 8,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Read returns the old contents when reading and writing one address together.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== design/channel_power_energy_meter.sv =====
// Top level of the channel power and energy meter: sample stream in, per-channel meters out.
//
// Takes one channel sample per clock, unless the result stream stalls, and returns one
// result transaction per sample, in order. Each sample goes through three stages: the input
// stage registers the current times voltage product and starts a read of the channel's store
// entry (peak, energy, on-time) from a single-port-read RAM; the update stage takes the entry
// from the RAM read register, applies the peak compare and the saturating on-time and energy
// adds, and writes the entry back; the output stage adds the power and the energy into the
// sweep sums and holds the result until it is taken. Unless the output stalls, the sustained
// rate is one transaction per cycle, back to back even on the same channel, since the update
// stage forwards the entry it wrote last to the read that overlapped that write. Stages fill
// under output stall, so up to three samples sit in flight. Store entries are cleared by
// per-channel valid bits at reset, so the block takes samples straight out of reset.
// totals_valid travels as m_axis_tlast and equals the sample's last-channel flag; the sweep
// sums restart after it. tick_time_ns is written through the cfg channel, which is always
// ready; write it only while no sample is in flight.
module channel_power_energy_meter (
  input  logic                             clk_i,
  input  logic                             rst_ni,

  // Configuration: tick_time_ns.
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [cpem_pkg::TICK_W-1:0]      cfg_data_i,

  // Sample stream.
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [15:0] current_sample, [31:16] battery_millivolts, [34:32] channel_state, rest zero
  input  logic [cpem_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // [2:0] channel_index
  input  logic [cpem_pkg::CH_W-1:0]        s_axis_tuser,
  input  logic                             s_axis_tlast,   // last_channel

  // Result stream.
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [31:0] channel_power, [63:32] peak_power, [127:64] channel_energy,
  // [191:128] channel_on_time, [226:192] total_power, [290:227] total_energy, rest zero
  output logic [cpem_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  // [2:0] out_channel
  output logic [cpem_pkg::CH_W-1:0]        m_axis_tuser,
  output logic                             m_axis_tlast    // totals_valid
);

  localparam int CurLo = 0;
  localparam int MvLo  = cpem_pkg::CUR_W;
  localparam int StLo  = cpem_pkg::CUR_W + cpem_pkg::MV_W;
  localparam int PadW  = cpem_pkg::OUT_TDATA_W - cpem_pkg::OUT_FIELDS_W;

  // ---------------------------------------------------------------------------
  // Configuration register
  // ---------------------------------------------------------------------------
  logic [cpem_pkg::TICK_W-1:0] tick_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q <= cpem_pkg::TICK_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      tick_q <= cfg_data_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline control: each stage loads when empty or when it hands over.
  // ---------------------------------------------------------------------------
  logic s1_v_q, s2_v_q, o_v_q;
  logic o_ld, s2_ld, s1_ld;
  logic in_xfer, s1_adv, s2_adv;

  assign o_ld   = !o_v_q || m_axis_tready;
  assign s2_ld  = !s2_v_q || o_ld;
  assign s1_ld  = !s1_v_q || s2_ld;

  assign s_axis_tready = s1_ld;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign s1_adv        = s1_v_q && s2_ld;
  assign s2_adv        = s2_v_q && o_ld;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      o_v_q  <= 1'b0;
    end else begin
      if (s1_ld) s1_v_q <= in_xfer;
      if (s2_ld) s2_v_q <= s1_v_q;
      if (o_ld)  o_v_q  <= s2_v_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Input stage: multiply, launch store read
  // ---------------------------------------------------------------------------
  logic signed [cpem_pkg::CUR_W-1:0] in_cur;
  logic signed [cpem_pkg::MV_W:0]    in_mv;
  logic signed [cpem_pkg::PWR_W:0]   in_prod;

  assign in_cur  = $signed(s_axis_tdata[CurLo +: cpem_pkg::CUR_W]);
  assign in_mv   = $signed({1'b0, s_axis_tdata[MvLo +: cpem_pkg::MV_W]});
  assign in_prod = in_cur * in_mv;

  logic [cpem_pkg::CH_W-1:0]  s1_ch_q;
  logic [cpem_pkg::PWR_W-1:0] s1_pwr_q;
  logic [cpem_pkg::ST_W-1:0]  s1_st_q;
  logic                       s1_last_q;

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_ch_q   <= s_axis_tuser;
      s1_pwr_q  <= in_prod[cpem_pkg::PWR_W-1:0];
      s1_st_q   <= s_axis_tdata[StLo +: cpem_pkg::ST_W];
      s1_last_q <= s_axis_tlast;
    end
  end

  // ---------------------------------------------------------------------------
  // Channel store and update stage (read-modify-write)
  // ---------------------------------------------------------------------------
  logic [cpem_pkg::ADDR_W-1:0]  s1_addr;
  logic                         s1_ch_ok;
  logic                         ram_we;
  logic [cpem_pkg::ENTRY_W-1:0] ram_rdata;
  logic [cpem_pkg::CHANNELS-1:0] vld_q;
  cpem_pkg::entry_t             wb_q;
  logic [cpem_pkg::ADDR_W-1:0]  wb_addr_q;
  logic                         wb_v_q;
  logic                         ent_vld, fwd_hit, conducting;
  cpem_pkg::entry_t             old_ent, new_ent, res_ent;

  assign s1_addr  = cpem_pkg::ADDR_W'(s1_ch_q);
  assign s1_ch_ok = int'(s1_ch_q) < cpem_pkg::CHANNELS;
  assign ram_we   = s1_adv && s1_ch_ok;

  cpem_ram #(
    .Width (cpem_pkg::ENTRY_W),
    .Depth (cpem_pkg::CHANNELS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (s1_addr),
    .wdata_i (new_ent),
    .re_i    (in_xfer),
    .raddr_i (cpem_pkg::ADDR_W'(s_axis_tuser)),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    ent_vld    = s1_ch_ok && vld_q[s1_addr];
    fwd_hit    = wb_v_q && (wb_addr_q == s1_addr);
    conducting = s1_st_q inside {cpem_pkg::ST_ON, cpem_pkg::ST_OC_ON, cpem_pkg::ST_OP_ON};

    // Latest entry: never written reads as zero; a write on the read edge is forwarded.
    if (!ent_vld) begin
      old_ent = '0;
    end else if (fwd_hit) begin
      old_ent = wb_q;
    end else begin
      old_ent = cpem_pkg::entry_t'(ram_rdata);
    end

    new_ent = old_ent;
    if ($signed(s1_pwr_q) > $signed(old_ent.peak)) begin
      new_ent.peak = s1_pwr_q;
    end
    if (conducting) begin
      new_ent.energy  = cpem_pkg::sat_add_s64(old_ent.energy,
                          {{(cpem_pkg::ENE_W-cpem_pkg::PWR_W){s1_pwr_q[cpem_pkg::PWR_W-1]}},
                           s1_pwr_q});
      new_ent.on_time = cpem_pkg::sat_add_u64(old_ent.on_time,
                          {{(cpem_pkg::ONT_W-cpem_pkg::TICK_W){1'b0}}, tick_q});
    end

    res_ent = s1_ch_ok ? new_ent : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      wb_v_q <= 1'b0;
    end else if (ram_we) begin
      vld_q[s1_addr] <= 1'b1;
      wb_v_q         <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ram_we) begin
      wb_q      <= new_ent;
      wb_addr_q <= s1_addr;
    end
  end

  logic [cpem_pkg::CH_W-1:0]  s2_ch_q;
  logic [cpem_pkg::PWR_W-1:0] s2_pwr_q;
  cpem_pkg::entry_t           s2_ent_q;
  logic                       s2_last_q;

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      s2_ch_q   <= s1_ch_q;
      s2_pwr_q  <= s1_pwr_q;
      s2_ent_q  <= res_ent;
      s2_last_q <= s1_last_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Output stage: sweep sums and result register
  // ---------------------------------------------------------------------------
  logic [cpem_pkg::TP_W-1:0]  psum_q, psum_d, psum_add;
  logic [cpem_pkg::ENE_W-1:0] esum_q, esum_d, esum_add;

  always_comb begin
    psum_add = cpem_pkg::sat_add_tp(psum_q, s2_pwr_q);
    esum_add = cpem_pkg::sat_add_s64(esum_q, s2_ent_q.energy);
    psum_d   = psum_q;
    esum_d   = esum_q;
    if (s2_adv) begin
      psum_d = s2_last_q ? '0 : psum_add;
      esum_d = s2_last_q ? '0 : esum_add;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      psum_q <= '0;
      esum_q <= '0;
    end else begin
      psum_q <= psum_d;
      esum_q <= esum_d;
    end
  end

  logic [cpem_pkg::CH_W-1:0]  o_ch_q;
  logic [cpem_pkg::PWR_W-1:0] o_pwr_q;
  cpem_pkg::entry_t           o_ent_q;
  logic [cpem_pkg::TP_W-1:0]  o_tp_q;
  logic [cpem_pkg::ENE_W-1:0] o_te_q;
  logic                       o_last_q;

  always_ff @(posedge clk_i) begin
    if (s2_adv) begin
      o_ch_q   <= s2_ch_q;
      o_pwr_q  <= s2_pwr_q;
      o_ent_q  <= s2_ent_q;
      o_tp_q   <= s2_last_q ? psum_add : '0;
      o_te_q   <= s2_last_q ? esum_add : '0;
      o_last_q <= s2_last_q;
    end
  end

  assign m_axis_tvalid = o_v_q;
  assign m_axis_tuser  = o_ch_q;
  assign m_axis_tlast  = o_last_q;
  assign m_axis_tdata  = {{PadW{1'b0}}, o_te_q, o_tp_q, o_ent_q.on_time, o_ent_q.energy,
                          o_ent_q.peak, o_pwr_q};

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // Peak starts at zero and only rises, so a reported peak is never negative.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    o_v_q |-> !o_ent_q.peak[cpem_pkg::PWR_W-1])
    else $error("negative peak power reported");

  // Totals are zero unless the transaction closes a sweep.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (o_v_q && !o_last_q) |-> (o_tp_q == '0 && o_te_q == '0))
    else $error("totals nonzero outside end of sweep");

  // Sweep sums restart after the last channel of a sweep.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_adv && s2_last_q) |=> (psum_q == '0 && esum_q == '0))
    else $error("sweep sums not cleared after end of sweep");

  // A forwarded entry always belongs to a channel that has been written.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_v_q && s1_ch_ok && fwd_hit) |-> ent_vld)
    else $error("forward hit on never-written channel");

  // An empty input stage never blocks the sample stream.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_v_q |-> s_axis_tready)
    else $error("input stalled with empty update stage");

endmodule

// ===== bench/tb_channel_power_energy_meter.sv =====
// Self-checking testbench for the channel power and energy meter, scoreboard included.
module tb_channel_power_energy_meter;
  timeunit 1ns;
  timeprecision 1ps;

  // Channel state codes the package leaves unnamed: off and the four tripped states.
  localparam logic [cpem_pkg::ST_W-1:0] ST_OFF   = 3'd0;
  localparam logic [cpem_pkg::ST_W-1:0] ST_TRIP0 = 3'd4;
  localparam logic [cpem_pkg::ST_W-1:0] ST_TRIP1 = 3'd5;
  localparam logic [cpem_pkg::ST_W-1:0] ST_TRIP2 = 3'd6;
  localparam logic [cpem_pkg::ST_W-1:0] ST_TRIP3 = 3'd7;

  // Saturation limits of the 64-bit sums and of the 35-bit sweep power sum.
  localparam longint S64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam longint S64_MIN = 64'h8000_0000_0000_0000;
  localparam longint TP_HI   = (64'sd1 <<< (cpem_pkg::TP_W - 1)) - 1;
  localparam longint TP_LO   = -(64'sd1 <<< (cpem_pkg::TP_W - 1));

  // Cycle limit for the hard stop; it leaves a wide margin.
  localparam int CYCLE_LIMIT = 500000;
  localparam int PHASE_ITEMS = 585;

  typedef struct packed {
    logic [cpem_pkg::CH_W-1:0]  ch;
    logic [cpem_pkg::CUR_W-1:0] cur;   // two's complement milliamps
    logic [cpem_pkg::MV_W-1:0]  mv;
    logic [cpem_pkg::ST_W-1:0]  st;
    logic                       last;
  } sample_t;

  typedef struct packed {
    logic [cpem_pkg::CH_W-1:0]  ch;
    logic [cpem_pkg::PWR_W-1:0] power;
    logic [cpem_pkg::PWR_W-1:0] peak;
    logic [cpem_pkg::ENE_W-1:0] energy;
    logic [cpem_pkg::ONT_W-1:0] on_time;
    logic [cpem_pkg::TP_W-1:0]  total_power;
    logic [cpem_pkg::ENE_W-1:0] total_energy;
    logic                       totals_valid;
  } meter_result_t;

  // Shadow of the meter: per-channel stores, sweep sums and the tick register.
  // note_sample() predicts one result per accepted sample; check_result() pops it.
  class meter_scoreboard;
    logic [cpem_pkg::TICK_W-1:0]       tick_ns;
    logic signed [cpem_pkg::PWR_W-1:0] peak_by_ch [cpem_pkg::CHANNELS];
    longint                            energy_by_ch [cpem_pkg::CHANNELS];
    logic [cpem_pkg::ONT_W-1:0]        on_time_by_ch [cpem_pkg::CHANNELS];
    longint                            sweep_power;
    longint                            sweep_energy;
    meter_result_t                     pending_q [$];
    int                                errors;
    int                                checked;
    int                                totals_seen;
    int                                clamped_sums;

    function new();
      tick_ns = cpem_pkg::TICK_RESET;
      for (int i = 0; i < cpem_pkg::CHANNELS; i++) begin
        peak_by_ch[i]    = '0;
        energy_by_ch[i]  = 0;
        on_time_by_ch[i] = '0;
      end
      sweep_power  = 0;
      sweep_energy = 0;
      errors       = 0;
      checked      = 0;
      totals_seen  = 0;
      clamped_sums = 0;
    endfunction

    function longint add_clamped(longint a, longint b);
      longint s;
      s = a + b;
      if (b > 0 && s < a) return S64_MAX;
      if (b < 0 && s > a) return S64_MIN;
      return s;
    endfunction

    function void note_sample(sample_t s);
      meter_result_t              r;
      longint                     amps;
      longint                     volts;
      longint                     prod;
      longint                     tp;
      longint                     e_now;
      logic [cpem_pkg::ONT_W:0]   wide;
      logic [cpem_pkg::ONT_W-1:0] t_now;
      logic                       conducting;
      int                         idx;
      amps  = {{(64 - cpem_pkg::CUR_W){s.cur[cpem_pkg::CUR_W-1]}}, s.cur};
      volts = {{(64 - cpem_pkg::MV_W){1'b0}}, s.mv};
      prod  = amps * volts;
      idx   = int'(s.ch);
      conducting = (s.st == cpem_pkg::ST_ON) || (s.st == cpem_pkg::ST_OC_ON) ||
                   (s.st == cpem_pkg::ST_OP_ON);
      r = '0;
      r.ch    = s.ch;
      r.power = prod[cpem_pkg::PWR_W-1:0];
      e_now   = 0;
      t_now   = '0;
      if (idx < cpem_pkg::CHANNELS) begin
        if (prod > longint'(peak_by_ch[idx])) peak_by_ch[idx] = prod[cpem_pkg::PWR_W-1:0];
        if (conducting) begin
          wide = {1'b0, on_time_by_ch[idx]} +
                 {{(cpem_pkg::ONT_W + 1 - cpem_pkg::TICK_W){1'b0}}, tick_ns};
          on_time_by_ch[idx] = wide[cpem_pkg::ONT_W] ? '1 : wide[cpem_pkg::ONT_W-1:0];
          energy_by_ch[idx]  = add_clamped(energy_by_ch[idx], prod);
        end
        r.peak = peak_by_ch[idx];
        e_now  = energy_by_ch[idx];
        t_now  = on_time_by_ch[idx];
      end
      r.energy  = e_now;
      r.on_time = t_now;
      // Sweep power sum clamps at the 35-bit limits
      tp = sweep_power + prod;
      if (tp > TP_HI) begin
        tp = TP_HI;
        clamped_sums++;
      end else if (tp < TP_LO) begin
        tp = TP_LO;
        clamped_sums++;
      end
      sweep_power  = tp;
      sweep_energy = add_clamped(sweep_energy, e_now);
      if (s.last) begin
        r.total_power  = sweep_power[cpem_pkg::TP_W-1:0];
        r.total_energy = sweep_energy;
        r.totals_valid = 1'b1;
        sweep_power    = 0;
        sweep_energy   = 0;
      end
      pending_q.push_back(r);
    endfunction

    function void compare_field(string field, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
      end
    endfunction

    function void check_result(meter_result_t got);
      meter_result_t want;
      checked++;
      if (pending_q.size() == 0) begin
        errors++;
        $display("%0t: result on channel %0d with no sample outstanding", $time, got.ch);
        return;
      end
      want = pending_q.pop_front();
      if (want.totals_valid) totals_seen++;
      compare_field("out_channel", 64'(want.ch), 64'(got.ch));
      compare_field("channel_power", 64'(want.power), 64'(got.power));
      compare_field("peak_power", 64'(want.peak), 64'(got.peak));
      compare_field("channel_energy", want.energy, got.energy);
      compare_field("channel_on_time", want.on_time, got.on_time);
      compare_field("total_power", 64'(want.total_power), 64'(got.total_power));
      compare_field("total_energy", want.total_energy, got.total_energy);
      compare_field("totals_valid", 64'(want.totals_valid), 64'(got.totals_valid));
    endfunction
  endclass

  // DUT-facing signals; every input starts at a known value.
  logic                             clk_i         = 1'b0;
  logic                             rst_ni        = 1'b0;
  logic                             cfg_valid_i   = 1'b0;
  logic                             cfg_ready_o;
  logic [cpem_pkg::TICK_W-1:0]      cfg_data_i    = '0;
  logic                             s_axis_tvalid = 1'b0;
  logic                             s_axis_tready;
  logic [cpem_pkg::IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic [cpem_pkg::CH_W-1:0]        s_axis_tuser  = '0;
  logic                             s_axis_tlast  = 1'b0;
  logic                             m_axis_tvalid;
  logic                             m_axis_tready = 1'b0;
  logic [cpem_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
  logic [cpem_pkg::CH_W-1:0]        m_axis_tuser;
  logic                             m_axis_tlast;

  meter_scoreboard meter_sb;
  int              cycle_count  = 0;
  int              sent         = 0;
  int              tick_writes  = 0;
  int              tx_calm_left = 0;   // sender transactions left in a no-gap stretch
  int              rx_calm_left = 0;   // receiver transactions left in a no-stall stretch

  channel_power_energy_meter uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #6 clk_i = ~clk_i;

  // Hard stop in case a handshake never completes.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Random wait before the next transaction, or none during a calm stretch.
  function automatic int draw_wait(inout int calm_left);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) calm_left = $urandom_range(10, 40);
    return $urandom_range(0, 6);
  endfunction

  // Field extremes show up often; the rest is uniform.
  function automatic logic [15:0] pick_word();
    logic [15:0] w;
    w = 16'($urandom);
    case ($urandom_range(0, 7))
      0: w = 16'h0000;
      1: w = 16'hFFFF;
      2: w = 16'h7FFF;
      3: w = 16'h8000;
      default: ;
    endcase
    return w;
  endfunction

  // Mostly conducting so the energy and on-time stores keep moving.
  function automatic logic [cpem_pkg::ST_W-1:0] pick_state();
    logic [cpem_pkg::ST_W-1:0] st;
    if ($urandom_range(0, 9) < 7)
      st = cpem_pkg::ST_W'($urandom_range(cpem_pkg::ST_ON, cpem_pkg::ST_OP_ON));
    else st = cpem_pkg::ST_W'($urandom_range(0, 7));
    return st;
  endfunction

  function automatic sample_t make_sample(input logic [cpem_pkg::CH_W-1:0] ch,
                                          input logic [15:0] cur, input logic [15:0] mv,
                                          input logic [cpem_pkg::ST_W-1:0] st,
                                          input logic last);
    sample_t s;
    s.ch   = ch;
    s.cur  = cur;
    s.mv   = mv;
    s.st   = st;
    s.last = last;
    return s;
  endfunction

  // One sample transaction; the prediction is taken at the accepting edge.
  task automatic send_sample(input sample_t s);
    int                              gap;
    logic [cpem_pkg::IN_TDATA_W-1:0] word;
    gap = draw_wait(tx_calm_left);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    word = '0;
    word[cpem_pkg::CUR_W-1:0]                 = s.cur;
    word[cpem_pkg::CUR_W+cpem_pkg::MV_W-1:cpem_pkg::CUR_W] = s.mv;
    word[cpem_pkg::CUR_W+cpem_pkg::MV_W+cpem_pkg::ST_W-1:cpem_pkg::CUR_W+cpem_pkg::MV_W] =
      s.st;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= word;
    s_axis_tuser  <= s.ch;
    s_axis_tlast  <= s.last;
    do @(posedge clk_i); while (!s_axis_tready);
    meter_sb.note_sample(s);
    sent++;
  endtask

  // Stop sending and let every outstanding result come back.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (meter_sb.pending_q.size() != 0) @(posedge clk_i);
  endtask

  // tick_time_ns write; only called with the pipeline empty.
  task automatic write_tick(input logic [cpem_pkg::TICK_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    meter_sb.tick_ns = value;
    tick_writes++;
  endtask

  // Ordinary sweep over consecutive channels, flagged last on its final sample.
  task automatic sweep_pass();
    int n;
    int base;
    n    = $urandom_range(1, cpem_pkg::CHANNELS);
    base = $urandom_range(0, cpem_pkg::CHANNELS - 1);
    for (int k = 0; k < n; k++)
      send_sample(make_sample(cpem_pkg::CH_W'((base + k) % cpem_pkg::CHANNELS), pick_word(),
                              pick_word(), pick_state(), k == n - 1));
  endtask

  // Long sweep of near-extreme powers of one sign: drives the 35-bit sweep sum into its clamp.
  task automatic overflow_sweep();
    int          n;
    logic        neg;
    logic [15:0] cur;
    n   = $urandom_range(9, 14);
    neg = 1'($urandom_range(0, 1));
    for (int k = 0; k < n; k++) begin
      cur = neg ? 16'h8000 + 16'($urandom_range(0, 3)) : 16'h7FFF - 16'($urandom_range(0, 3));
      send_sample(make_sample(cpem_pkg::CH_W'($urandom_range(0, cpem_pkg::CHANNELS - 1)), cur,
                              16'hFFFF - 16'($urandom_range(0, 15)), pick_state(),
                              k == n - 1));
    end
  endtask

  // Mix of well-formed sweeps, saturating sweeps and unstructured samples.
  task automatic random_phase(input int count);
    int stop;
    stop = sent + count;
    while (sent < stop) begin
      case ($urandom_range(0, 9))
        0:       overflow_sweep();
        1, 2:    send_sample(make_sample(cpem_pkg::CH_W'($urandom), pick_word(), pick_word(),
                                         cpem_pkg::ST_W'($urandom),
                                         1'($urandom_range(0, 1))));
        default: sweep_pass();
      endcase
    end
  endtask

  // Result side: random ready stalls, check on every accepted transaction.
  initial begin
    int            stall;
    meter_result_t got;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      stall = draw_wait(rx_calm_left);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready));
      got.ch           = m_axis_tuser;
      got.power        = m_axis_tdata[31:0];
      got.peak         = m_axis_tdata[63:32];
      got.energy       = m_axis_tdata[127:64];
      got.on_time      = m_axis_tdata[191:128];
      got.total_power  = m_axis_tdata[226:192];
      got.total_energy = m_axis_tdata[290:227];
      got.totals_valid = m_axis_tlast;
      meter_sb.check_result(got);
    end
  end

  // Main sequence: reset, directed corners, then three random phases at different tick values.
  initial begin
    meter_sb = new();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed corners at the reset tick value.
    send_sample(make_sample(3'd0, 16'h7FFF, 16'hFFFF, cpem_pkg::ST_ON, 1'b0));     // max power
    send_sample(make_sample(3'd1, 16'h8000, 16'hFFFF, cpem_pkg::ST_OC_ON, 1'b0));  // min power
    send_sample(make_sample(3'd2, 16'hFFFF, 16'hFFFF, cpem_pkg::ST_OP_ON, 1'b0));  // small neg
    send_sample(make_sample(3'd3, 16'h7FFF, 16'h0000, ST_OFF, 1'b0));    // zero volts, off
    send_sample(make_sample(3'd4, 16'h0001, 16'h0001, ST_TRIP0, 1'b0));
    send_sample(make_sample(3'd5, 16'h1234, 16'h8000, ST_TRIP1, 1'b0));
    send_sample(make_sample(3'd6, 16'h8000, 16'h0001, ST_TRIP2, 1'b0));
    send_sample(make_sample(3'd7, 16'h7FFF, 16'hFFFF, ST_TRIP3, 1'b1));  // tripped: peak only
    send_sample(make_sample(3'd0, 16'h7FFF, 16'hFFFF, cpem_pkg::ST_ON, 1'b1));  // one-sample
    send_sample(make_sample(3'd0, 16'h8000, 16'hFFFF, cpem_pkg::ST_ON, 1'b0));  // peak held
    send_sample(make_sample(3'd0, 16'h0000, 16'h0000, ST_OFF, 1'b0));
    send_sample(make_sample(3'd1, 16'h8000, 16'hFFFF, cpem_pkg::ST_OC_ON, 1'b0));
    send_sample(make_sample(3'd1, 16'h8000, 16'hFFFF, cpem_pkg::ST_OP_ON, 1'b1));  // energy < 0
    drain();

    // Smallest tick.
    write_tick(32'd1);
    random_phase(PHASE_ITEMS);
    drain();

    // Largest tick.
    write_tick(32'hFFFF_FFFF);
    random_phase(PHASE_ITEMS);
    drain();

    // Somewhere in between.
    write_tick($urandom_range(2, 32'hFFFF_FFFE));
    random_phase(PHASE_ITEMS);
    drain();

    // Pipeline is three deep; give any stray result time to show up.
    repeat (20) @(posedge clk_i);

    $display("Run covered %0d samples over %0d tick settings, %0d results checked.",
             sent, tick_writes + 1, meter_sb.checked);
    $display("Sweep totals reported: %0d; sweep power sum clamped %0d times.",
             meter_sb.totals_seen, meter_sb.clamped_sums);
    if (meter_sb.errors == 0 && meter_sb.pending_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
